### design/sdta_pkg.sv
package sdta_pkg;

  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 16;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;

  // 2^63 has 19 decimal digits; one spare cell keeps the row at the text limit
  localparam int NUM_DIGITS = 20;
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count_before;
  } num_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] count_after;
  } chr_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHIFT_BIT,
    CELL_SHIFT_DIGIT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

endpackage

### design/sdta_bcd_cell.sv
module sdta_bcd_cell (
  input  logic                            clk,
  input  sdta_pkg::cell_op_t              op,
  input  logic                            bit_in,
  output logic                            bit_out,
  input  logic [sdta_pkg::DIGIT_W-1:0]    digit_in,
  output logic [sdta_pkg::DIGIT_W-1:0]    digit
);
  import sdta_pkg::*;

  logic [DIGIT_W-1:0] adj;
  logic [DIGIT_W-1:0] digit_next;

  // add-3 correction before the doubling step
  assign adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_comb begin
    unique case (op)
      CELL_HOLD:        digit_next = digit;
      CELL_CLEAR:       digit_next = '0;
      CELL_SHIFT_BIT:   digit_next = {adj[DIGIT_W-2:0], bit_in};
      CELL_SHIFT_DIGIT: digit_next = digit_in;
      default:          digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

### design/sdta_digit_chain.sv
module sdta_digit_chain (
  input  logic                            clk,
  input  sdta_pkg::cell_op_t              op,
  input  logic                            bit_in,
  output logic [sdta_pkg::DIGIT_W-1:0]    top_digit
);
  import sdta_pkg::*;

  logic [NUM_DIGITS:0]               carry;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_from_below;

  assign carry[0] = bit_in;

  genvar i;
  generate
    for (i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
        assign digit_from_below[i] = '0;
      end else begin : g_up
        assign digit_from_below[i] = digits[i-1];
      end
      sdta_bcd_cell u_cell (
        .clk      (clk),
        .op       (op),
        .bit_in   (carry[i]),
        .bit_out  (carry[i+1]),
        .digit_in (digit_from_below[i]),
        .digit    (digits[i])
      );
    end
  endgenerate

  // carry out of the top cell is zero while a 64-bit magnitude shifts in; both arms pick the top digit
  assign top_digit = carry[NUM_DIGITS] ? digits[NUM_DIGITS-1] : digits[NUM_DIGITS-1];

endmodule

### design/signed_decimal_to_ascii.sv
// conversion: the magnitude shifts through the bcd cell row one bit per cycle, leading
//   zeros are skipped keeping at least one digit, then the characters go out one per
//   cycle while chr_ready allows, a minus sign first when negative; the first character
//   comes sooner for longer numbers, and a new number is taken only back in idle after
//   the last character has been emitted
// reset: rst (synchronous, active high) returns to idle and drops chr_valid
module signed_decimal_to_ascii (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 num_valid,
  output logic                 num_ready,
  input  sdta_pkg::num_t       num,
  output logic                 chr_valid,
  input  logic                 chr_ready,
  output sdta_pkg::chr_t       chr
);
  import sdta_pkg::*;

  state_t                state, state_next;
  cell_op_t              op;
  logic [VALUE_W-1:0]    mag;
  logic                  neg_pend;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_inc;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [REM_W-1:0]      rem;
  logic [DIGIT_W-1:0]    top_digit;
  logic                  slot_free;
  logic                  load;
  logic                  emit;
  logic                  skip_shift;

  // double-dabble row: magnitude enters msb first, digits leave from the top cell
  sdta_digit_chain u_chain (
    .clk       (clk),
    .op        (op),
    .bit_in    (mag[VALUE_W-1]),
    .top_digit (top_digit)
  );

  // output register frees when empty or being taken this cycle
  assign slot_free = !chr_valid || chr_ready;
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

  always_comb begin
    state_next = state;
    op         = CELL_HOLD;
    num_ready  = 1'b0;
    load       = 1'b0;
    emit       = 1'b0;
    skip_shift = 1'b0;
    unique case (state)
      ST_IDLE: begin
        num_ready = 1'b1;
        if (num_valid) begin
          load       = 1'b1;
          op         = CELL_CLEAR;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        op = CELL_SHIFT_BIT;
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_digit == '0 && rem > REM_W'(1)) begin
          op         = CELL_SHIFT_DIGIT;
          skip_shift = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!neg_pend) begin
            op = CELL_SHIFT_DIGIT;
            if (rem == REM_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chr_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        chr_valid <= 1'b1;
      end else if (chr_ready) begin
        chr_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load) begin
      neg_pend <= num.value[VALUE_W-1];
      mag      <= num.value[VALUE_W-1] ? (~num.value + 1'b1) : num.value;
      count    <= num.count_before;
      bit_cnt  <= BIT_CNT_W'(VALUE_W - 1);
      rem      <= REM_W'(NUM_DIGITS);
    end else begin
      if (state == ST_CONVERT) begin
        mag     <= {mag[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (skip_shift) begin
        rem <= rem - 1'b1;
      end
      if (emit) begin
        count           <= count_inc;
        chr.count_after <= count_inc;
        if (neg_pend) begin
          neg_pend      <= 1'b0;
          chr.character <= ASCII_MINUS;
          chr.last      <= 1'b0;
        end else begin
          rem           <= rem - 1'b1;
          chr.character <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
          chr.last      <= (rem == REM_W'(1));
        end
      end
    end
  end

endmodule

### design/sdta_checker.sv
module sdta_checker (
  input logic            clk,
  input logic            rst,
  input logic            num_valid,
  input logic            num_ready,
  input sdta_pkg::num_t  num,
  input logic            chr_valid,
  input logic            chr_ready,
  input sdta_pkg::chr_t  chr
);
  import sdta_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !chr_valid)
    else $error("chr_valid high right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    chr_valid && !chr_ready |=> chr_valid && $stable(chr))
    else $error("stalled item changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    num_valid && num_ready |=> !num_ready)
    else $error("new number taken while converting");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    chr_valid |-> chr.character == ASCII_MINUS ||
                  (chr.character >= ASCII_ZERO && chr.character <= ASCII_NINE))
    else $error("character outside sign and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    chr_valid && chr.character == ASCII_MINUS |-> !chr.last)
    else $error("sign marked as last character");

endmodule

bind signed_decimal_to_ascii sdta_checker u_sdta_checker (.*);
